// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the RC4 datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the module's clk_i / rst_ni.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4_pkg
// Types and constants shared by the RC4 controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  // Default key store depth in bytes.
  localparam int unsigned KEY_MAX_DEF = 256;

  // S-box geometry.
  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned SBOX_AW    = 8;

  typedef logic [7:0] byte_t;

  // Input command codes.
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Datapath operation issued by the controller each cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY,     // store key byte
    OP_INIT,    // S[n] = n
    OP_KS_RD,   // read S[n] and key[kpos]
    OP_KS_MIX,  // mix += S[n] + key, read S[mix]
    OP_KS_WN,   // S[n] = S[mix]
    OP_KS_WM,   // S[mix] = old S[n], advance n and kpos
    OP_RD_I,    // i += 1, read S[i]
    OP_RD_J,    // j += S[i], read S[j]
    OP_WR_I,    // S[i] = S[j], read S[S[i] + S[j]]
    OP_WR_J,    // S[j] = old S[i], emit data XOR keystream
    OP_PASS     // emit data unchanged
  } dp_op_e;

  // Controller to datapath.
  typedef struct packed {
    logic   load_item;
    dp_op_e op;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic keyed;     // a key schedule has completed
    logic item_last; // last flag of the held transaction
    logic n_end;     // schedule counter at its final entry
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rc4_ctrl.sv -----
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key loading, key schedule and per-byte keystream steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_cmd_i,
  output logic                 in_ready_o,
  input  rc4_pkg::dp_stat_t    stat_i,
  output rc4_pkg::ctrl_cmd_t   cmd_o
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY,
    ST_INIT,
    ST_KS_RD,
    ST_KS_MIX,
    ST_KS_WN,
    ST_KS_WM,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J,
    ST_PASS
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.load_item = 1'b0;
    cmd_o.op        = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          if (in_cmd_i == CMD_KEY) begin
            state_d = ST_KEY;
          end else if (stat_i.keyed) begin
            state_d = ST_RD_I;
          end else begin
            state_d = ST_PASS;
          end
        end
      end
      ST_KEY: begin
        cmd_o.op = OP_KEY;
        state_d  = stat_i.item_last ? ST_INIT : ST_IDLE;
      end
      ST_INIT: begin
        cmd_o.op = OP_INIT;
        if (stat_i.n_end) state_d = ST_KS_RD;
      end
      ST_KS_RD: begin
        cmd_o.op = OP_KS_RD;
        state_d  = ST_KS_MIX;
      end
      ST_KS_MIX: begin
        cmd_o.op = OP_KS_MIX;
        state_d  = ST_KS_WN;
      end
      ST_KS_WN: begin
        cmd_o.op = OP_KS_WN;
        state_d  = ST_KS_WM;
      end
      ST_KS_WM: begin
        cmd_o.op = OP_KS_WM;
        state_d  = stat_i.n_end ? ST_IDLE : ST_KS_RD;
      end
      ST_RD_I: begin
        cmd_o.op = OP_RD_I;
        state_d  = ST_RD_J;
      end
      ST_RD_J: begin
        cmd_o.op = OP_RD_J;
        state_d  = ST_WR_I;
      end
      ST_WR_I: begin
        cmd_o.op = OP_WR_I;
        state_d  = ST_WR_J;
      end
      ST_WR_J: begin
        // hold until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.op = OP_WR_J;
          state_d  = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_PASS;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_dpath.sv -----
// ----------------------------------------------------------------------------
// rc4_dpath
// S-box and key store memories, stream indices and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rc4_dpath #(
  parameter int unsigned KeyMax = rc4_pkg::KEY_MAX_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rc4_pkg::ctrl_cmd_t   cmd_i,
  output rc4_pkg::dp_stat_t    stat_o,
  input  wire [7:0]            in_byte_i,
  input  wire                  in_last_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);
  import rc4_pkg::*;

  localparam int unsigned KeyAw  = (KeyMax > 1) ? $clog2(KeyMax) : 1;
  localparam int unsigned KeyCntW = $clog2(KeyMax + 1);

  // Memories
  byte_t sbox_mem [SBOX_DEPTH];
  byte_t key_mem  [KeyMax];

  logic               s_we, s_re;
  logic [SBOX_AW-1:0] s_wa, s_ra;
  byte_t              s_wd, s_rd_q;
  logic               k_we, k_re;
  byte_t              k_rd_q;

  // Held transaction
  byte_t byte_q;
  logic  last_q;

  // Stream and schedule state
  logic [KeyCntW-1:0] key_count_q;
  byte_t              i_q, j_q, n_q, mix_q, si_q, sj_q, t_q;
  logic [KeyAw-1:0]   kpos_q;
  logic               keyed_q;

  // Output register
  logic  out_valid_q, out_last_q, out_load;
  byte_t out_byte_q, out_byte_d;

  byte_t              mix_d, i_d, j_d, t_d, ks;
  logic [KeyCntW:0]   kpos_inc;
  logic               key_room;

  assign key_room = key_count_q < KeyCntW'(KeyMax);
  assign kpos_inc = (KeyCntW + 1)'(kpos_q) + 1'b1;
  assign mix_d    = mix_q + s_rd_q + k_rd_q;
  assign i_d      = i_q + 8'd1;
  assign j_d      = j_q + s_rd_q;
  assign t_d      = si_q + s_rd_q;

  // Keystream byte, forwarding the swap that was just written
  always_comb begin
    priority if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = s_rd_q;
    end
  end

  // Memory port control per operation
  always_comb begin
    s_we       = 1'b0;
    s_re       = 1'b0;
    s_wa       = n_q;
    s_wd       = n_q;
    s_ra       = n_q;
    k_we       = 1'b0;
    k_re       = 1'b0;
    out_load   = 1'b0;
    out_byte_d = byte_q;
    unique case (cmd_i.op)
      OP_KEY:    k_we = key_room;
      OP_INIT:   s_we = 1'b1;
      OP_KS_RD: begin
        s_re = 1'b1;
        k_re = 1'b1;
      end
      OP_KS_MIX: begin
        s_re = 1'b1;
        s_ra = mix_d;
      end
      OP_KS_WN: begin
        s_we = 1'b1;
        s_wd = s_rd_q;
      end
      OP_KS_WM: begin
        s_we = 1'b1;
        s_wa = mix_q;
        s_wd = si_q;
      end
      OP_RD_I: begin
        s_re = 1'b1;
        s_ra = i_d;
      end
      OP_RD_J: begin
        s_re = 1'b1;
        s_ra = j_d;
      end
      OP_WR_I: begin
        s_we = 1'b1;
        s_wa = i_q;
        s_wd = s_rd_q;
        s_re = 1'b1;
        s_ra = t_d;
      end
      OP_WR_J: begin
        s_we       = 1'b1;
        s_wa       = j_q;
        s_wd       = si_q;
        out_load   = 1'b1;
        out_byte_d = byte_q ^ ks;
      end
      OP_PASS:   out_load = 1'b1;
      OP_NONE:   ;
      default:   ;
    endcase
  end

  // S-box memory, registered read
  always_ff @(posedge clk_i) begin
    if (s_we) sbox_mem[s_wa] <= s_wd;
    if (s_re) s_rd_q <= sbox_mem[s_ra];
  end

  // Key store memory, registered read
  always_ff @(posedge clk_i) begin
    if (k_we) key_mem[key_count_q[KeyAw-1:0]] <= byte_q;
    if (k_re) k_rd_q <= key_mem[kpos_q];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (cmd_i.op == OP_KS_MIX) si_q <= s_rd_q;
    if (cmd_i.op == OP_RD_J)   si_q <= s_rd_q;
    if (cmd_i.op == OP_WR_I) begin
      sj_q <= s_rd_q;
      t_q  <= t_d;
    end
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= last_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      mix_q       <= '0;
      kpos_q      <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_KEY: begin
          if (key_room) key_count_q <= key_count_q + 1'b1;
        end
        OP_INIT: begin
          n_q    <= n_q + 8'd1;
          mix_q  <= '0;
          kpos_q <= '0;
        end
        OP_KS_MIX: mix_q <= mix_d;
        OP_KS_WM: begin
          n_q    <= n_q + 8'd1;
          kpos_q <= (kpos_inc >= {1'b0, key_count_q}) ? '0 : KeyAw'(kpos_inc);
          if (n_q == '1) begin
            i_q         <= '0;
            j_q         <= '0;
            key_count_q <= '0;
            keyed_q     <= 1'b1;
          end
        end
        OP_RD_I:   i_q <= i_d;
        OP_RD_J:   j_q <= j_d;
        default:   ;
      endcase
      // output handshake
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.keyed     = keyed_q;
  assign stat_o.item_last = last_q;
  assign stat_o.n_end     = (n_q == '1);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Checks
  `ASSERT_DEF(a_no_overwrite, out_load |-> (!out_valid_q || out_ready_i), "result overwritten")
  `ASSERT_DEF(a_key_count_max, key_count_q <= KeyCntW'(KeyMax), "key count above depth")
  `ASSERT_DEF(a_sched_done, (cmd_i.op == OP_KS_WM && n_q == '1) |=> (keyed_q && key_count_q == '0 && i_q == '0 && j_q == '0), "schedule end state wrong")

endmodule

`default_nettype wire

// ----- hw/rtl/rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte stream cipher: key loading, key schedule and keystream XOR.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. A key byte is accepted, then stored.
// A data byte is accepted, then runs RD_I, RD_J, WR_I and WR_J, and WR_J loads
// its result (before any key is scheduled, PASS loads it). Its two dependent
// S-box reads, two swap writes and the keystream read all share the S-box
// memory's one read port and one write port, and the reads are registered.
// The final key byte is followed by the key schedule, which loads the identity
// S-box and then mixes each S-box entry with a read, a mix and two writes; no
// transaction is accepted until it ends. A finished result sits in an output
// register; the next transaction is taken while it waits, and a data byte
// behind it holds in its last step until the register frees up.
`default_nettype none

module rc4_stream_cipher #(
  parameter int unsigned KeyMax = rc4_pkg::KEY_MAX_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire        cmd_i,
  input  wire [7:0]  in_byte_i,
  input  wire        last_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import rc4_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (cmd_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  rc4_dpath #(
    .KeyMax (KeyMax)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .in_byte_i   (in_byte_i),
    .in_last_i   (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for rc4_stream_cipher. Key and data transactions
// are queued up front and driven over a valid/ready channel with random
// gaps and output back-pressure. A local keystream predictor follows every
// accepted transaction, and each result is checked against it in order.
// ----------------------------------------------------------------------------

module tb;

  import rc4_pkg::*;

  localparam int unsigned RandomItems  = 750;
  localparam int unsigned SettleCycles = 1400;  // covers a full key schedule
  localparam int unsigned PhaseLen     = 50;

  typedef enum int unsigned {
    PH_NONE,
    PH_SEND,
    PH_RECV,
    PH_BOTH
  } idle_phase_e;

  typedef struct {
    logic        cmd;
    logic [7:0]  value;
    logic        last;
    bit          drain;  // hold off until all results are back
    idle_phase_e phase;
  } cipher_item_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       out_last;
  } cipher_result_t;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       cmd      = CMD_KEY;
  logic [7:0] in_byte  = '0;
  logic       last     = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  cipher_item_t   item_q[$];
  cipher_result_t cipher_out_q[$];
  cipher_item_t   drive_item;
  cipher_result_t want;
  idle_phase_e    cur_phase = PH_NONE;
  int unsigned    stim_count = 0;
  int unsigned    errors = 0;

  // Predictor state
  logic [7:0] sbox_m [SBOX_DEPTH];
  logic [7:0] key_m  [KEY_MAX_DEF];
  int unsigned key_cnt_m = 0;
  logic [7:0] idx_i_m = '0;
  logic [7:0] idx_j_m = '0;
  bit         keyed_m = 1'b0;

  rc4_stream_cipher u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .in_byte_i   (in_byte),
    .last_i      (last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last)
  );

  always #5 clk = ~clk;

  function automatic int unsigned send_idle_pct(input idle_phase_e ph);
    return (ph == PH_SEND) ? 85 : (ph == PH_BOTH) ? 31 : 0;
  endfunction

  function automatic int unsigned recv_stall_pct(input idle_phase_e ph);
    return (ph == PH_RECV) ? 85 : (ph == PH_BOTH) ? 31 : 0;
  endfunction

  // Advance the keystream model by one accepted transaction
  function automatic void apply_rc4_item(input logic c, input logic [7:0] v,
                                         input logic l);
    cipher_result_t r;
    logic [7:0]     mix;
    logic [7:0]     tmp;
    int unsigned    kpos;
    int unsigned    klen;
    if (c == CMD_KEY) begin
      if (key_cnt_m < KEY_MAX_DEF) begin
        key_m[key_cnt_m] = v;
        key_cnt_m++;
      end
      if (l) begin
        // Key schedule over the bytes held so far
        klen = (key_cnt_m == 0) ? 1 : key_cnt_m;
        for (int n = 0; n < SBOX_DEPTH; n++) sbox_m[n] = 8'(n);
        mix  = '0;
        kpos = 0;
        for (int n = 0; n < SBOX_DEPTH; n++) begin
          mix         = mix + sbox_m[n] + key_m[kpos];
          tmp         = sbox_m[n];
          sbox_m[n]   = sbox_m[mix];
          sbox_m[mix] = tmp;
          kpos++;
          if (kpos >= klen) kpos = 0;
        end
        idx_i_m   = '0;
        idx_j_m   = '0;
        key_cnt_m = 0;
        keyed_m   = 1'b1;
      end
      return;
    end
    r.out_last = l;
    if (!keyed_m) begin
      r.out_byte = v;
    end else begin
      idx_i_m          = idx_i_m + 8'd1;
      idx_j_m          = idx_j_m + sbox_m[idx_i_m];
      tmp              = sbox_m[idx_i_m];
      sbox_m[idx_i_m]  = sbox_m[idx_j_m];
      sbox_m[idx_j_m]  = tmp;
      r.out_byte       = v ^ sbox_m[8'(sbox_m[idx_i_m] + sbox_m[idx_j_m])];
    end
    cipher_out_q.push_back(r);
  endfunction

  task automatic push_item(input logic c, input logic [7:0] v, input logic l,
                           input bit drain = 1'b0);
    cipher_item_t it;
    it.cmd   = c;
    it.value = v;
    it.last  = l;
    it.drain = drain;
    it.phase = idle_phase_e'((stim_count / PhaseLen) % 4);
    item_q.push_back(it);
    stim_count++;
  endtask

  // One random session: a clean key load plus data burst, a rekey while the
  // stream runs, or loose noise. forced_klen > 0 forces a clean key load.
  task automatic add_session(input int unsigned idx, input int unsigned forced_klen);
    int unsigned kind;
    int unsigned klen;
    int unsigned nd;
    int unsigned r;
    kind = (forced_klen != 0) ? 0 : $urandom_range(99);
    if (kind < 75) begin
      r    = $urandom_range(99);
      klen = (forced_klen != 0) ? forced_klen :
             (r < 70) ? $urandom_range(16, 1) :
             (r < 95) ? $urandom_range(64, 17) : $urandom_range(256, 200);
      for (int unsigned n = 0; n < klen; n++)
        push_item(CMD_KEY, 8'($urandom_range(255)), n == klen - 1,
                  n == 0 && idx % 8 == 0);
      nd = $urandom_range(40, 4);
      for (int unsigned n = 0; n < nd; n++)
        push_item(CMD_DATA, 8'($urandom_range(255)),
                  n == nd - 1 || $urandom_range(7) == 0);
    end else if (kind < 90) begin
      // Rekey with data interleaved before the final key byte
      klen = $urandom_range(12, 1);
      for (int unsigned n = 0; n < klen; n++) begin
        if ($urandom_range(1) == 1)
          push_item(CMD_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
        push_item(CMD_KEY, 8'($urandom_range(255)), n == klen - 1);
      end
      nd = $urandom_range(12, 1);
      for (int unsigned n = 0; n < nd; n++)
        push_item(CMD_DATA, 8'($urandom_range(255)), n == nd - 1);
    end else begin
      nd = $urandom_range(30, 6);
      for (int unsigned n = 0; n < nd; n++) begin
        if ($urandom_range(2) == 0)
          push_item(CMD_KEY, 8'($urandom_range(255)), $urandom_range(3) == 0);
        else
          push_item(CMD_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Driver: present the next queued transaction once the slot is free
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cmd      <= CMD_KEY;
      in_byte  <= '0;
      last     <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (item_q.size() != 0 &&
          (!item_q[0].drain ||
           (cipher_out_q.size() == 0 && !(in_valid && cmd == CMD_DATA))) &&
          $urandom_range(99) >= send_idle_pct(item_q[0].phase)) begin
        drive_item = item_q.pop_front();
        in_valid  <= 1'b1;
        cmd       <= drive_item.cmd;
        in_byte   <= drive_item.value;
        last      <= drive_item.last;
        cur_phase <= drive_item.phase;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
    end
  end

  // Monitor: check results in order, then fold in any accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (cipher_out_q.size() == 0) begin
          $display("%0t: unexpected result, out_byte %h out_last %b",
                   $time, out_byte, out_last);
          errors++;
        end else begin
          want = cipher_out_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, want.out_byte, out_byte);
            errors++;
          end
          if (out_last !== want.out_last) begin
            $display("%0t: out_last mismatch, expected %b, actual %b",
                     $time, want.out_last, out_last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) apply_rc4_item(cmd, in_byte, last);
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned sess;
    int unsigned target;

    // Data before any key passes straight through
    push_item(CMD_DATA, 8'h00, 1'b0);
    push_item(CMD_DATA, 8'hFF, 1'b1);
    push_item(CMD_DATA, 8'hA5, 1'b0);
    push_item(CMD_DATA, 8'h5A, 1'b1);
    // Shortest key, extreme byte values
    push_item(CMD_KEY,  8'h00, 1'b1);
    push_item(CMD_DATA, 8'h00, 1'b0);
    push_item(CMD_DATA, 8'hFF, 1'b1);
    push_item(CMD_KEY,  8'hFF, 1'b0, 1'b1);
    push_item(CMD_KEY,  8'h01, 1'b0);
    push_item(CMD_KEY,  8'h80, 1'b1);
    push_item(CMD_DATA, 8'h00, 1'b0);
    push_item(CMD_DATA, 8'hFF, 1'b0);
    push_item(CMD_DATA, 8'h3C, 1'b1);
    // Rekey mid-stream: data keeps the old keystream until the last key byte
    push_item(CMD_KEY,  8'h7E, 1'b0);
    push_item(CMD_DATA, 8'h11, 1'b0);
    push_item(CMD_DATA, 8'h22, 1'b1);
    push_item(CMD_KEY,  8'hC3, 1'b1);
    push_item(CMD_DATA, 8'hEE, 1'b1, 1'b1);
    push_item(CMD_DATA, 8'h81, 1'b0);

    // Random sessions; one overfills the key store, one fills it exactly
    target = stim_count + RandomItems;
    sess   = 0;
    while (stim_count < target) begin
      add_session(sess, (sess == 3) ? 260 : (sess == 9) ? 256 : 0);
      if (sess == 3) stim_count -= 4;  // bytes past a full store are dropped
      sess++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (item_q.size() != 0 || in_valid) @(posedge clk);
    while (cipher_out_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (errors == 0) begin
      $display("rc4_stream_cipher regression: pass");
    end else begin
      $display("rc4_stream_cipher regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("rc4_stream_cipher regression: fail");
    $finish;
  end

endmodule
